### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// They assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/c8sc_pkg.sv
// Shared types, constants and ChaCha round functions for the ChaCha8 stream cipher.
// No dependencies.
`default_nettype none

package c8sc_pkg;

  localparam int NUM_WORDS = 16;
  localparam int N_STG     = 16;  // half-rounds in the keystream pipeline
  localparam int KQ_DEPTH  = 4;   // keystream blocks queued plus in flight
  localparam int KQ_AW     = 2;
  localparam int KQ_CW     = 3;
  localparam int IQ_DEPTH  = 2;   // item queue between front and back
  localparam int IQ_CW     = 2;
  localparam int CFG_IW    = 3;

  localparam logic [CFG_IW-1:0] REG_KEY01 = 3'd0;
  localparam logic [CFG_IW-1:0] REG_KEY23 = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KEY45 = 3'd2;
  localparam logic [CFG_IW-1:0] REG_KEY67 = 3'd3;
  localparam logic [CFG_IW-1:0] REG_NONCE = 3'd4;

  localparam logic [3:0] FULL_CNT = 4'd8;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [NUM_WORDS-1:0][31:0] blk_t;

  typedef struct packed {
    logic [63:0] in_data;
    logic [3:0]  in_bytes;
    logic        in_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  out_bytes;
    logic        out_last;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;       // clamped byte count
    logic        last;
    logic        take_new;  // item opens a fresh keystream block
    logic [2:0]  pos;       // chunk within the block
  } cmd_t;

  typedef struct packed {
    logic key_wr;
    logic nonce_wr;
  } cfg_evt_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Half of a column or diagonal round: either the 16/12 or the 8/7 steps
  // of all four quarter rounds.
  function automatic blk_t half_round(input blk_t s, input logic diag, input logic second);
    blk_t        w;
    int          a;
    int          b;
    int          c;
    int          d;
    int unsigned r1;
    int unsigned r2;
    w  = s;
    r1 = second ? 8 : 16;
    r2 = second ? 7 : 12;
    for (int i = 0; i < 4; i++) begin
      a = i;
      b = 4 + ((i + (diag ? 1 : 0)) & 3);
      c = 8 + ((i + (diag ? 2 : 0)) & 3);
      d = 12 + ((i + (diag ? 3 : 0)) & 3);
      w[a] = w[a] + w[b];
      w[d] = rotl32(w[d] ^ w[a], r1);
      w[c] = w[c] + w[d];
      w[b] = rotl32(w[b] ^ w[c], r2);
    end
    return w;
  endfunction

  function automatic blk_t init_state(input logic [255:0] key, input logic [63:0] ctr,
                                      input logic [63:0] nonce);
    return {nonce, ctr, key, SIGMA3, SIGMA2, SIGMA1, SIGMA0};
  endfunction

  function automatic blk_t add_blk(input blk_t x, input blk_t y);
    blk_t r;
    for (int i = 0; i < NUM_WORDS; i++) begin
      r[i] = x[i] + y[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/chacha8_stream_cipher.sv
// ChaCha8 stream cipher. Input items carry up to eight message bytes on
// in_payload (valid/stall); each result item on out_payload carries the same
// bytes XORed with keystream, unused bytes zero. Encrypt and decrypt are the same.
// Configuration: cfg_we with cfg_index 0..3 writes the key, index 4 the nonce
// (which also restarts the block counter at zero); other indexes are ignored.
// An accepted item is written into the item queue and issued from there into
// the output register that drives out_valid, once its keystream block is queued.
// Throughput: one item per cycle within a message of full chunks while out_stall
// is low. Keystream comes from a 16-stage half-round pipeline whose result is
// added to the input state as it enters the queue, with up to four blocks queued
// or in flight. Every message starts on a fresh block, so a run of one-chunk
// messages waits on the keystream pipeline.
// Reset and every key or nonce write flush the keystream queue. While out_stall
// is high the result holds and up to two more items fill the two-entry item queue
// before in_stall rises.
// Depends on c8sc_pkg, c8sc_front, c8sc_ksgen, c8sc_back.
`default_nettype none

module chacha8_stream_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [c8sc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [63:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  c8sc_pkg::in_item_t            in_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output c8sc_pkg::out_item_t           out_payload
);
  import c8sc_pkg::*;

  logic [3:0][63:0] key_r;
  logic [63:0]      nonce_r;
  cfg_evt_t         cfg_evt;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic ks_valid;
  blk_t ks_block;
  logic ks_pop;

  assign cfg_evt.key_wr   = cfg_we && (cfg_index <= REG_KEY67);
  assign cfg_evt.nonce_wr = cfg_we && (cfg_index == REG_NONCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY01: key_r[0] <= cfg_wdata;
        REG_KEY23: key_r[1] <= cfg_wdata;
        REG_KEY45: key_r[2] <= cfg_wdata;
        REG_KEY67: key_r[3] <= cfg_wdata;
        REG_NONCE: nonce_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  c8sc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_evt    (cfg_evt),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  c8sc_ksgen u_ksgen (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_evt  (cfg_evt),
    .key      (key_r),
    .nonce    (nonce_r),
    .ks_pop   (ks_pop),
    .ks_valid (ks_valid),
    .ks_block (ks_block)
  );

  c8sc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .ks_valid    (ks_valid),
    .ks_block    (ks_block),
    .ks_pop      (ks_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

### src/c8sc_front.sv
// Front end: accepts input items, tracks block position and queues classified items.
// Depends on c8sc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module c8sc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  c8sc_pkg::cfg_evt_t cfg_evt,
  input  logic               in_valid,
  output logic               in_stall,
  input  c8sc_pkg::in_item_t in_payload,
  output logic               cmd_valid,
  output c8sc_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);
  import c8sc_pkg::*;

  logic             loaded_r, loaded_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic [IQ_CW-1:0] qcnt_r, qcnt_nxt;
  logic             wptr_r, rptr_r;
  cmd_t             q_mem [IQ_DEPTH];

  logic       accept;
  logic [3:0] cnt;
  logic       take_new;
  logic [2:0] pos;
  logic       ends;
  cmd_t       new_cmd;

  assign in_stall  = (qcnt_r == IQ_CW'(IQ_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (qcnt_r != '0);
  assign cmd       = q_mem[rptr_r];

  always_comb begin
    cnt      = (in_payload.in_bytes > FULL_CNT) ? FULL_CNT : in_payload.in_bytes;
    take_new = (cnt != '0) && !loaded_r;
    pos      = take_new ? 3'd0 : pos_r;
    // short chunk or last flag closes the message and drops the block
    ends     = in_payload.in_last || (cnt != FULL_CNT);

    new_cmd.data     = in_payload.in_data;
    new_cmd.cnt      = cnt;
    new_cmd.last     = in_payload.in_last;
    new_cmd.take_new = take_new;
    new_cmd.pos      = pos;

    loaded_nxt = loaded_r;
    pos_nxt    = pos_r;
    if (cfg_evt.nonce_wr) begin
      loaded_nxt = 1'b0;
      pos_nxt    = '0;
    end else if (accept) begin
      if (ends) begin
        loaded_nxt = 1'b0;
        pos_nxt    = '0;
      end else begin
        loaded_nxt = (pos != 3'd7);
        pos_nxt    = pos + 3'd1;
      end
    end

    qcnt_nxt = qcnt_r + IQ_CW'(accept) - IQ_CW'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      pos_r    <= '0;
      qcnt_r   <= '0;
      wptr_r   <= 1'b0;
      rptr_r   <= 1'b0;
    end else begin
      loaded_r <= loaded_nxt;
      pos_r    <= pos_nxt;
      qcnt_r   <= qcnt_nxt;
      if (accept) begin
        wptr_r <= ~wptr_r;
      end
      if (cmd_pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wptr_r] <= new_cmd;
    end
  end

  `ASSERT_PROP(a_pop_has_item, cmd_pop |-> cmd_valid, "item popped from empty queue")
  `ASSERT_PROP(a_new_block_at_start, (cmd_valid && cmd.take_new) |-> (cmd.pos == 3'd0),
               "fresh block must start at chunk zero")
  `ASSERT_NEVER(a_pos_without_block, !loaded_r && (pos_r != 3'd0),
                "chunk position set with no block in use")

endmodule

`default_nettype wire

### src/c8sc_ksgen.sv
// Keystream generator: 16-stage half-round ChaCha8 pipeline feeding a block queue.
// Depends on c8sc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module c8sc_ksgen (
  input  logic               clk,
  input  logic               rst_n,
  input  c8sc_pkg::cfg_evt_t cfg_evt,
  input  logic [255:0]       key,
  input  logic [63:0]        nonce,
  input  logic               ks_pop,
  output logic               ks_valid,
  output c8sc_pkg::blk_t     ks_block
);
  import c8sc_pkg::*;

  blk_t             st_r  [N_STG+1];
  logic [63:0]      ctr_r [N_STG+1];
  logic [N_STG:0]   vld_r, vld_nxt;
  logic [63:0]      gen_ctr_r, gen_ctr_nxt;
  logic [63:0]      cons_ctr_r, cons_ctr_nxt;
  logic [KQ_CW-1:0] fcnt_r, fcnt_nxt;
  logic [KQ_CW-1:0] infl_r, infl_nxt;
  logic [KQ_AW-1:0] wptr_r, rptr_r;
  blk_t             kq_mem [KQ_DEPTH];

  logic           flush;
  logic           issue;
  logic           push;
  logic [KQ_CW:0] used;
  blk_t           out_blk;

  assign flush    = cfg_evt.key_wr || cfg_evt.nonce_wr;
  assign used     = {1'b0, fcnt_r} + {1'b0, infl_r};
  // a block is started only if the queue has room reserved for it
  assign issue    = !flush && (used < (KQ_CW+1)'(KQ_DEPTH));
  assign push     = vld_r[N_STG] && !flush;
  assign ks_valid = (fcnt_r != '0);
  assign ks_block = kq_mem[rptr_r];
  assign out_blk  = add_blk(st_r[N_STG], init_state(key, ctr_r[N_STG], nonce));

  always_comb begin
    vld_nxt      = {vld_r[N_STG-1:0], issue};
    infl_nxt     = infl_r + KQ_CW'(issue) - KQ_CW'(vld_r[N_STG]);
    fcnt_nxt     = fcnt_r + KQ_CW'(push) - KQ_CW'(ks_pop);
    gen_ctr_nxt  = issue ? gen_ctr_r + 64'd1 : gen_ctr_r;
    cons_ctr_nxt = ks_pop ? cons_ctr_r + 64'd1 : cons_ctr_r;
    if (flush) begin
      vld_nxt  = '0;
      infl_nxt = '0;
      fcnt_nxt = '0;
    end
    // restart from the next block the back end will take
    if (cfg_evt.nonce_wr) begin
      gen_ctr_nxt  = '0;
      cons_ctr_nxt = '0;
    end else if (cfg_evt.key_wr) begin
      gen_ctr_nxt = cons_ctr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      infl_r     <= '0;
      fcnt_r     <= '0;
      gen_ctr_r  <= '0;
      cons_ctr_r <= '0;
      wptr_r     <= '0;
      rptr_r     <= '0;
    end else begin
      vld_r      <= vld_nxt;
      infl_r     <= infl_nxt;
      fcnt_r     <= fcnt_nxt;
      gen_ctr_r  <= gen_ctr_nxt;
      cons_ctr_r <= cons_ctr_nxt;
      if (flush) begin
        wptr_r <= '0;
        rptr_r <= '0;
      end else begin
        if (push) begin
          wptr_r <= wptr_r + KQ_AW'(1);
        end
        if (ks_pop) begin
          rptr_r <= rptr_r + KQ_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r[0]  <= init_state(key, gen_ctr_r, nonce);
    ctr_r[0] <= gen_ctr_r;
    if (push) begin
      kq_mem[wptr_r] <= out_blk;
    end
  end

  for (genvar s = 0; s < N_STG; s++) begin : g_stage
    localparam logic DIAG   = ((s / 2) % 2) == 1;
    localparam logic SECOND = (s % 2) == 1;
    always_ff @(posedge clk) begin
      st_r[s+1]  <= half_round(st_r[s], DIAG, SECOND);
      ctr_r[s+1] <= ctr_r[s];
    end
  end

  `ASSERT_PROP(a_credit_bound, used <= (KQ_CW+1)'(KQ_DEPTH),
               "queued plus in-flight blocks exceed queue depth")
  `ASSERT_PROP(a_infl_count, infl_r == KQ_CW'($countones(vld_r)),
               "in-flight count disagrees with pipeline valid bits")
  `ASSERT_PROP(a_pop_nonempty, ks_pop |-> ks_valid, "keystream block taken from empty queue")

endmodule

`default_nettype wire

### src/c8sc_back.sv
// Back end: selects the keystream chunk, XORs and masks it, and holds the output register.
// Depends on c8sc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module c8sc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  c8sc_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                ks_valid,
  input  c8sc_pkg::blk_t      ks_block,
  output logic                ks_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output c8sc_pkg::out_item_t out_payload
);
  import c8sc_pkg::*;

  blk_t      cur_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r;

  logic        go;
  blk_t        src;
  logic [63:0] ks;
  logic [63:0] mask;
  out_item_t   res;

  assign go          = cmd_valid && (!cmd.take_new || ks_valid) &&
                       (!out_valid_r || !out_stall);
  assign cmd_pop     = go;
  assign ks_pop      = go && cmd.take_new;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  always_comb begin
    src = cmd.take_new ? ks_block : cur_r;
    ks  = {src[{cmd.pos, 1'b1}], src[{cmd.pos, 1'b0}]};
    for (int j = 0; j < 8; j++) begin
      mask[8*j +: 8] = {8{(4'(j) < cmd.cnt)}};
    end
    res.out_data  = (cmd.data ^ ks) & mask;
    res.out_bytes = cmd.cnt;
    res.out_last  = cmd.last;

    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ks_pop) begin
      cur_r <= ks_block;
    end
    if (go) begin
      out_r <= res;
    end
  end

  `ASSERT_PROP(a_block_ready, (cmd_pop && cmd.take_new) |-> ks_valid,
               "item issued without a keystream block")
  `ASSERT_PROP(a_result_follows, cmd_pop |=> out_valid_r, "issued item produced no result")
  `ASSERT_PROP(a_bytes_range, out_valid_r |-> (out_r.out_bytes <= FULL_CNT),
               "output byte count above eight")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for chacha8_stream_cipher: random message traffic with
// idle and stall, checked against a ChaCha8 keystream predictor built in this file.
// Depends on c8sc_pkg and the cipher RTL.
`timescale 1ns / 1ps

module tb_top;
  import c8sc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYC  = 40;   // block pipeline depth plus margin
  localparam int MAX_WAIT    = 14;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IW-1:0]     cfg_index  = '0;
  logic [63:0]           cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  in_item_t              in_payload = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  out_item_t             out_payload;

  chacha8_stream_cipher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state
  logic [63:0] key_reg [4];
  logic [63:0] nonce_reg;
  logic [63:0] blk_ctr;
  logic [2:0]  chunk_idx;
  logic        blk_live;
  logic [31:0] ks_words [16];
  logic [31:0] mix [16];

  in_item_t    pt_pend [$];   // plaintext items waiting for the driver
  out_item_t   ct_due [$];    // predicted cipher items
  int          n_pushed  = 0;
  int          n_taken   = 0;
  int          n_err     = 0;
  int          cycle_cnt = 0;
  int          in_gap    = 0;
  int          stall_left = 0;
  bit          in_taken  = 1'b0;
  bit          out_taken = 1'b0;
  bit          in_idle   = 1'b1;
  bit          out_idle  = 1'b1;

  function automatic logic [31:0] rol(logic [31:0] v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void qr(int a, int b, int c, int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rol(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rol(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rol(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rol(mix[b] ^ mix[c], 7);
  endfunction

  function automatic void refill_keystream();
    logic [31:0] seed [16];
    seed[0] = SIGMA0;
    seed[1] = SIGMA1;
    seed[2] = SIGMA2;
    seed[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      seed[4 + 2 * i] = key_reg[i][31:0];
      seed[5 + 2 * i] = key_reg[i][63:32];
    end
    seed[12] = blk_ctr[31:0];
    seed[13] = blk_ctr[63:32];
    seed[14] = nonce_reg[31:0];
    seed[15] = nonce_reg[63:32];
    for (int i = 0; i < 16; i++) mix[i] = seed[i];
    for (int r = 0; r < 4; r++) begin
      qr(0, 4, 8, 12); qr(1, 5, 9, 13); qr(2, 6, 10, 14); qr(3, 7, 11, 15);
      qr(0, 5, 10, 15); qr(1, 6, 11, 12); qr(2, 7, 8, 13); qr(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + seed[i];
    blk_ctr   = blk_ctr + 64'd1;
    chunk_idx = '0;
    blk_live  = 1'b1;
  endfunction

  function automatic out_item_t cipher_chunk(in_item_t it);
    logic [3:0]  n;
    logic [63:0] ks;
    logic [63:0] mask;
    out_item_t   r;
    n  = (it.in_bytes > FULL_CNT) ? FULL_CNT : it.in_bytes;
    ks = '0;
    if (n != 0) begin
      if (!blk_live) refill_keystream();
      ks = {ks_words[2 * chunk_idx + 1], ks_words[2 * chunk_idx]};
    end
    mask = (n >= FULL_CNT) ? '1 : ((64'd1 << (8 * int'(n))) - 64'd1);
    r.out_data  = (it.in_data ^ ks) & mask;
    r.out_bytes = n;
    r.out_last  = it.in_last;
    // short or last chunk ends the message and drops the rest of the block
    if (it.in_last || n < FULL_CNT) begin
      blk_live  = 1'b0;
      chunk_idx = '0;
    end else begin
      chunk_idx = chunk_idx + 3'd1;
      if (chunk_idx == 0) blk_live = 1'b0;
    end
    return r;
  endfunction

  function automatic void push_chunk(logic [63:0] d, logic [3:0] n, logic l);
    in_item_t it;
    it.in_data  = d;
    it.in_bytes = n;
    it.in_last  = l;
    pt_pend.push_back(it);
    n_pushed++;
  endfunction

  function automatic logic [63:0] rand_data();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Waits until every item went in and every result came out, then lets the
  // keystream prefetch settle.
  task automatic drain();
    @(negedge clk);
    while (n_taken != n_pushed || ct_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Mostly well-formed messages, a few loose chunks with odd counts.
  task automatic gen_traffic(int n_items);
    int added;
    int len;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int i = 1; i < len; i++) push_chunk(rand_data(), FULL_CNT, 1'b0);
        case ($urandom_range(0, 3))
          0, 1: push_chunk(rand_data(), 4'($urandom_range(1, 8)), 1'b1);
          2: push_chunk(rand_data(), 4'($urandom_range(1, 7)), 1'b0);
          default: push_chunk(rand_data(), FULL_CNT, 1'b0);  // message left open
        endcase
        added += len;
      end else begin
        push_chunk(rand_data(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  // Input driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pt_pend.size() != 0) begin
        in_payload <= pt_pend.pop_front();
        in_valid   <= 1'b1;
        in_gap     <= in_idle ? $urandom_range(0, MAX_WAIT) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stall: a fresh wait is drawn after each accepted result
  always @(negedge clk) begin
    if (out_taken) begin
      stall_left = out_idle ? $urandom_range(0, MAX_WAIT) : 0;
    end
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: config mirror, prediction, checking
  always @(posedge clk) begin
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == REG_NONCE) begin
          nonce_reg = cfg_wdata;
          blk_ctr   = '0;
          blk_live  = 1'b0;
        end else if (cfg_index < REG_NONCE) begin
          key_reg[cfg_index[1:0]] = cfg_wdata;
        end
      end
      if (in_valid && !in_stall) begin
        ct_due.push_back(cipher_chunk(in_payload));
        n_taken++;
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (ct_due.size() == 0) begin
          n_err++;
          $error("unexpected item: out_data %h out_bytes %0d out_last %0d",
                 out_payload.out_data, out_payload.out_bytes, out_payload.out_last);
        end else begin
          out_item_t want;
          want = ct_due.pop_front();
          if (want.out_data !== out_payload.out_data) begin
            n_err++;
            $error("out_data: expected %h, actual %h", want.out_data, out_payload.out_data);
          end
          if (want.out_bytes !== out_payload.out_bytes) begin
            n_err++;
            $error("out_bytes: expected %0d, actual %0d", want.out_bytes,
                   out_payload.out_bytes);
          end
          if (want.out_last !== out_payload.out_last) begin
            n_err++;
            $error("out_last: expected %0d, actual %0d", want.out_last,
                   out_payload.out_last);
          end
        end
        out_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce_reg = '0;
    blk_ctr   = '0;
    chunk_idx = '0;
    blk_live  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, block rollover, message ends, odd counts
    push_chunk('0, FULL_CNT, 1'b0);
    push_chunk('1, FULL_CNT, 1'b0);
    for (int i = 0; i < 6; i++) push_chunk(rand_data(), FULL_CNT, 1'b0);
    push_chunk('1, FULL_CNT, 1'b0);           // ninth chunk: next block
    push_chunk(rand_data(), 4'd3, 1'b0);      // short chunk ends the message
    push_chunk(rand_data(), 4'd0, 1'b0);      // zero count
    push_chunk('1, 4'd0, 1'b1);
    push_chunk('1, 4'd15, 1'b0);              // oversize count
    push_chunk(rand_data(), 4'd9, 1'b1);
    push_chunk('1, 4'd1, 1'b1);
    push_chunk(rand_data(), 4'd7, 1'b0);
    push_chunk('1, FULL_CNT, 1'b1);
    push_chunk(rand_data(), FULL_CNT, 1'b0);
    push_chunk(rand_data(), 4'd0, 1'b0);      // zero count inside a message
    push_chunk(rand_data(), FULL_CNT, 1'b0);
    push_chunk(rand_data(), FULL_CNT, 1'b0);  // left open across the key change
    drain();

    // Key change keeps the loaded block
    for (int i = 0; i < 4; i++) write_reg(CFG_IW'(i), '1);
    in_idle  = 1'b0;
    out_idle = 1'b0;
    gen_traffic(100);
    drain();

    write_reg(REG_NONCE, '1);
    for (int i = 0; i < 4; i++) write_reg(CFG_IW'(i), {$urandom, $urandom});
    for (int i = REG_NONCE + 1; i < (1 << CFG_IW); i++)
      write_reg(CFG_IW'(i), {$urandom, $urandom});
    in_idle  = 1'b1;
    out_idle = 1'b1;
    gen_traffic(110);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 4; i++)
        if ($urandom_range(0, 1)) write_reg(CFG_IW'(i), rand_data());
      if (ph == 2) write_reg(REG_NONCE, '0);
      else if ($urandom_range(0, 1)) write_reg(REG_NONCE, rand_data());
      in_idle  = 1'($urandom_range(0, 1));
      out_idle = 1'($urandom_range(0, 1));
      gen_traffic(ph == 2 ? 120 : 110);
      drain();
    end

    if (n_err == 0 && ct_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
